>>> src/utf8d_pkg.sv
// Shared status codes and the result type of the lenient UTF-8 decoder.
package utf8d_pkg;

  localparam int unsigned CP_W = 21;
  localparam int unsigned ST_W = 2;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD_LEAD = 2'd1;
  localparam logic [ST_W-1:0] ST_TRUNC    = 2'd2;

  typedef struct packed {
    logic            has_res;
    logic [CP_W-1:0] code_point;
    logic [ST_W-1:0] status;
    logic            end_of_text;
  } utf8d_res_t;

endpackage

>>> src/utf8d_core.sv
// Sequence state and the per-word decode step of the lenient UTF-8 decoder.
module utf8d_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  logic [7:0]            text_byte,
  input  logic                  final_byte,
  output utf8d_pkg::utf8d_res_t res
);
  import utf8d_pkg::*;

  logic [1:0]      pend_r, pend_nxt;
  logic [CP_W-1:0] part_r, part_nxt;
  logic [CP_W-1:0] acc;
  logic [1:0]      pend_dec;

  assign acc      = {part_r[CP_W-7:0], text_byte[5:0]};
  assign pend_dec = pend_r - 2'd1;

  always_comb begin
    pend_nxt        = pend_r;
    part_nxt        = part_r;
    res.has_res     = 1'b0;
    res.code_point  = '0;
    res.status      = ST_OK;
    res.end_of_text = final_byte;
    if (pend_r != 2'd0) begin
      if (pend_dec == 2'd0) begin
        res.has_res    = 1'b1;
        res.code_point = acc;
        pend_nxt       = 2'd0;
        part_nxt       = '0;
      end else if (final_byte) begin
        res.has_res = 1'b1;
        res.status  = ST_TRUNC;
        pend_nxt    = 2'd0;
        part_nxt    = '0;
      end else begin
        pend_nxt = pend_dec;
        part_nxt = acc;
      end
    end else if (text_byte inside {[8'h00:8'h7F]}) begin
      res.has_res    = 1'b1;
      res.code_point = {{(CP_W-8){1'b0}}, text_byte};
    end else if (text_byte inside {[8'hC0:8'hF7]}) begin
      if (final_byte) begin
        res.has_res = 1'b1;
        res.status  = ST_TRUNC;
      end else if (text_byte inside {[8'hC0:8'hDF]}) begin
        pend_nxt = 2'd1;
        part_nxt = {{(CP_W-5){1'b0}}, text_byte[4:0]};
      end else if (text_byte inside {[8'hE0:8'hEF]}) begin
        pend_nxt = 2'd2;
        part_nxt = {{(CP_W-4){1'b0}}, text_byte[3:0]};
      end else begin
        pend_nxt = 2'd3;
        part_nxt = {{(CP_W-3){1'b0}}, text_byte[2:0]};
      end
    end else begin
      res.has_res = 1'b1;
      res.status  = ST_BAD_LEAD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
      part_r <= '0;
    end else if (fire) begin
      pend_r <= pend_nxt;
      part_r <= part_nxt;
    end
  end

  // An idle decoder holds no partial code point.
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r == 2'd0) |-> (part_r == '0))
    else $error("partial value left over while no sequence is open");

  // The last word of a string always closes any open sequence.
  a_final_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && final_byte) |=> (pend_r == 2'd0))
    else $error("sequence still open after the final word");

  // The last word of a string always gives a result.
  a_final_result: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && final_byte) |-> res.has_res)
    else $error("final word gave no result");

endmodule

>>> src/utf8_lenient_decoder.sv
// Top level of the lenient UTF-8 decoder: input register, decode step, result register.
// A word taken into the input register passes its result, if it gives one, into the result register and out_*.
// Throughput: one word per cycle while the result side takes a word every cycle.
// A waiting result holds the word in the input register, which then blocks the input.
// Reset (rst_n low, synchronous) empties both registers and closes any open sequence.
module utf8_lenient_decoder (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_text_byte,
  input  logic                        in_final_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [utf8d_pkg::CP_W-1:0]  out_code_point,
  output logic [utf8d_pkg::ST_W-1:0]  out_status,
  output logic                        out_end_of_text
);
  import utf8d_pkg::*;

  logic            in_v_r, in_v_nxt;
  logic [7:0]      byte_r;
  logic            fin_r;
  logic            out_v_r, out_v_nxt;
  logic [CP_W-1:0] cp_r;
  logic [ST_W-1:0] st_r;
  logic            eot_r;
  logic            out_free;
  logic            fire;
  utf8d_res_t      res;

  assign out_free = !out_v_r || out_ready;
  assign fire     = in_v_r && out_free;
  assign in_ready = !in_v_r || fire;

  utf8d_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .text_byte  (byte_r),
    .final_byte (fin_r),
    .res        (res)
  );

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_valid && in_ready) begin
      in_v_nxt = 1'b1;
    end else if (fire) begin
      in_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (fire) begin
      out_v_nxt = res.has_res;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_text_byte;
      fin_r  <= in_final_byte;
    end
    if (fire && res.has_res) begin
      cp_r  <= res.code_point;
      st_r  <= res.status;
      eot_r <= res.end_of_text;
    end
  end

  assign out_valid       = out_v_r;
  assign out_code_point  = cp_r;
  assign out_status      = st_r;
  assign out_end_of_text = eot_r;

  // Only ok results carry a code point.
  a_cp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && (st_r != ST_OK)) |-> (cp_r == '0))
    else $error("code point set on a result that is not ok");

  // A truncated result is always the end of a string.
  a_trunc_eot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && (st_r == ST_TRUNC)) |-> eot_r)
    else $error("truncated result without end of text");

  // A word in the input register moves on whenever the result side is free.
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && !out_v_r) |-> fire)
    else $error("input register held while the result register is empty");

endmodule
